// ===== rtl/rau_pkg.sv =====
package rau_pkg;

   // action codes carried in req_tuser
   localparam int ACT_W = 3;
   localparam logic [ACT_W-1:0] ACT_NORM = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_INV  = 3'd5;

   // result field widths
   localparam int RES_NUM_W = 33;
   localparam int RES_DEN_W = 31;
   localparam int RSP_TDATA_W = RES_NUM_W + RES_DEN_W;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/rau_divider.sv =====
module rau_divider #(
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WIDTH-1:0]      dividend,
   input  logic [WIDTH-1:0]      divisor,
   output rau_pkg::div_stat_type stat,
   output logic [WIDTH-1:0]      quotient,
   output logic [WIDTH-1:0]      remainder
);
   import rau_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff;
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[WIDTH-1:0];

endmodule

// ===== rtl/rational_arith_unit.sv =====
// Rational arithmetic unit: combines two signed fractions and returns the
// result reduced to lowest terms.
// Request channel: req_tuser carries the action (normalize a, add, subtract,
// multiply, divide, invert a); req_tdata carries a_num, a_den, b_num, b_den.
// Response channel: rsp_tdata carries res_num (33 bits) and res_den
// (31 bits); rsp_tuser flags a zero result denominator, which also means the
// result was left unreduced.
// Each operand and then the raw result is reduced with Euclid's algorithm,
// run on one shared restoring divider that yields one quotient bit per cycle.
// A remainder step issues a division, takes the quotient bits and waits for
// done; two closing divisions then take the numerator and denominator
// quotients by the gcd. A reduction skips the divider when the numerator or
// denominator is zero. Normalize reduces a, invert reduces a and then the
// swapped result, and the combined actions reduce a, b and the result, with
// three multiply steps and then an add and a sign step in between. One item
// is in work at a time; req_tready is high only while idle, so the next beat
// can be taken in the same cycle that rsp_tvalid rises, at the earliest. A
// stalled receiver holds the next result in the unit.
// Reset is synchronous and returns the unit to idle with no result pending.
module rational_arith_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // a_num, a_den, b_num, b_den from bit 0 up, zero padded to whole bytes
   input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] req_tdata,
   // action
   input  logic [rau_pkg::ACT_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // res_num, res_den from bit 0 up
   output logic [rau_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // den_zero
   output logic                              rsp_tuser
);
   import rau_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int DW = 2 * OPERAND_WIDTH;
   localparam int XW = (DW + 1 > RES_NUM_W) ? DW + 1 : RES_NUM_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_NORM  = 4'd1;
   localparam logic [3:0] S_GCD   = 4'd2;
   localparam logic [3:0] S_GCDW  = 4'd3;
   localparam logic [3:0] S_DIVNW = 4'd4;
   localparam logic [3:0] S_DIVDW = 4'd5;
   localparam logic [3:0] S_STORE = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_MULW  = 4'd8;
   localparam logic [3:0] S_ADD   = 4'd9;
   localparam logic [3:0] S_ABS   = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   localparam logic [1:0] PH_A = 2'd0;
   localparam logic [1:0] PH_B = 2'd1;
   localparam logic [1:0] PH_R = 2'd2;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
      mag_of = x[W-1] ? W'(-x) : x;
   endfunction

   logic [3:0]       state_ff, state_in;
   logic [1:0]       ph_ff, ph_in;
   logic [ACT_W-1:0] act_ff, act_in;
   logic [W-1:0]     bn_raw_ff, bn_raw_in, bd_raw_ff, bd_raw_in;
   logic [DW-1:0]    nmag_ff, nmag_in, dmag_ff, dmag_in;
   logic             nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic [DW-1:0]    m_ff, m_in, g_ff, g_in;
   logic [W-1:0]     an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic             an_neg_ff, an_neg_in, ad_neg_ff, ad_neg_in;
   logic             bn_neg_ff, bn_neg_in, bd_neg_ff, bd_neg_in;
   logic [1:0]       mstep_ff, mstep_in;
   logic [DW-1:0]    prod_ff, prod_in;
   logic             prod_neg_ff, prod_neg_in;
   logic [DW:0]      x0_ff, x0_in, x1_ff, x1_in;
   logic [DW-1:0]    x2_ff, x2_in;
   logic [DW:0]      sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_user_ff, rsp_user_in;

   logic             div_start;
   logic [DW-1:0]    div_a, div_b;
   div_stat_type     div_stat;
   logic [DW-1:0]    div_quo, div_rem;

   logic             req_fire;
   logic             is_bop;
   logic             fx_nneg;
   logic [W-1:0]     opx, opy;
   logic             sx, sy;
   logic [DW:0]      prod_signed;
   logic [DW:0]      sum_negv, x1_negv;
   logic [XW-1:0]    num_ext, num_val, den_ext;

   rau_divider #(.WIDTH(DW)) u_rau_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign is_bop     = act_ff inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV};

   // sign after reduction: the denominator's sign moves onto the numerator
   assign fx_nneg = (dmag_ff == '0) ? nneg_ff : ((nmag_ff != '0) && (nneg_ff ^ dneg_ff));

   // shared multiplier operand selection
   always_comb begin
      case (mstep_ff)
         2'd0: begin
            opx = an_ff;
            sx  = an_neg_ff;
            opy = (act_ff == ACT_MUL) ? bn_ff : bd_ff;
            sy  = (act_ff == ACT_MUL) ? bn_neg_ff : bd_neg_ff;
         end
         2'd1: begin
            opx = ad_ff;
            sx  = ad_neg_ff;
            opy = (act_ff == ACT_MUL) ? bd_ff : bn_ff;
            sy  = (act_ff == ACT_MUL) ? bd_neg_ff : bn_neg_ff;
         end
         default: begin
            opx = ad_ff;
            sx  = ad_neg_ff;
            opy = bd_ff;
            sy  = bd_neg_ff;
         end
      endcase
   end

   assign prod_signed = prod_neg_ff ? (-{1'b0, prod_ff}) : {1'b0, prod_ff};
   assign sum_negv    = -sum_ff;
   assign x1_negv     = -x1_ff;
   assign num_ext     = XW'(nmag_ff);
   assign num_val     = nneg_ff ? (-num_ext) : num_ext;
   assign den_ext     = XW'(dmag_ff);

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      act_in       = act_ff;
      bn_raw_in    = bn_raw_ff;
      bd_raw_in    = bd_raw_ff;
      nmag_in      = nmag_ff;
      dmag_in      = dmag_ff;
      nneg_in      = nneg_ff;
      dneg_in      = dneg_ff;
      m_in         = m_ff;
      g_in         = g_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      an_neg_in    = an_neg_ff;
      ad_neg_in    = ad_neg_ff;
      bn_neg_in    = bn_neg_ff;
      bd_neg_in    = bd_neg_ff;
      mstep_in     = mstep_ff;
      prod_in      = prod_ff;
      prod_neg_in  = prod_neg_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      sum_in       = sum_ff;
      div_start    = 1'b0;
      div_a        = nmag_ff;
      div_b        = g_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in    = req_tuser;
               nmag_in   = DW'(mag_of(req_tdata[W-1:0]));
               nneg_in   = req_tdata[W-1];
               dmag_in   = DW'(mag_of(req_tdata[2*W-1:W]));
               dneg_in   = req_tdata[2*W-1];
               bn_raw_in = req_tdata[3*W-1:2*W];
               bd_raw_in = req_tdata[4*W-1:3*W];
               ph_in     = PH_A;
               state_in  = S_NORM;
            end
         end
         S_NORM: begin
            if (dmag_ff == '0) begin
               state_in = S_STORE;
            end else if (nmag_ff == '0) begin
               dmag_in  = DW'(1);
               state_in = S_STORE;
            end else begin
               m_in     = nmag_ff;
               g_in     = dmag_ff;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (!div_stat.busy) begin
               div_start = 1'b1;
               if (m_ff == '0) begin
                  div_a    = nmag_ff;
                  div_b    = g_ff;
                  state_in = S_DIVNW;
               end else begin
                  div_a    = g_ff;
                  div_b    = m_ff;
                  state_in = S_GCDW;
               end
            end
         end
         S_GCDW: begin
            if (div_stat.done) begin
               g_in     = m_ff;
               m_in     = div_rem;
               state_in = S_GCD;
            end
         end
         S_DIVNW: begin
            // numerator quotient in, start the denominator right behind it
            if (div_stat.done) begin
               nmag_in   = div_quo;
               div_start = 1'b1;
               div_a     = dmag_ff;
               div_b     = g_ff;
               state_in  = S_DIVDW;
            end
         end
         S_DIVDW: begin
            if (div_stat.done) begin
               dmag_in  = div_quo;
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            nneg_in = fx_nneg;
            dneg_in = 1'b0;
            case (ph_ff)
               PH_A: begin
                  an_in     = nmag_ff[W-1:0];
                  an_neg_in = fx_nneg;
                  ad_in     = dmag_ff[W-1:0];
                  ad_neg_in = 1'b0;
                  if (is_bop) begin
                     nmag_in  = DW'(mag_of(bn_raw_ff));
                     nneg_in  = bn_raw_ff[W-1];
                     dmag_in  = DW'(mag_of(bd_raw_ff));
                     dneg_in  = bd_raw_ff[W-1];
                     ph_in    = PH_B;
                     state_in = S_NORM;
                  end else if (act_ff == ACT_INV) begin
                     // swap the reduced parts and reduce again
                     nmag_in  = dmag_ff;
                     nneg_in  = 1'b0;
                     dmag_in  = nmag_ff;
                     dneg_in  = fx_nneg;
                     ph_in    = PH_R;
                     state_in = S_NORM;
                  end else begin
                     state_in = S_OUT;
                  end
               end
               PH_B: begin
                  bn_in     = nmag_ff[W-1:0];
                  bn_neg_in = fx_nneg;
                  bd_in     = dmag_ff[W-1:0];
                  bd_neg_in = 1'b0;
                  mstep_in  = 2'd0;
                  state_in  = S_MUL;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_MUL: begin
            prod_in     = DW'(opx) * DW'(opy);
            prod_neg_in = sx ^ sy;
            state_in    = S_MULW;
         end
         S_MULW: begin
            case (mstep_ff)
               2'd0:    x0_in = prod_signed;
               2'd1:    x1_in = prod_signed;
               default: x2_in = prod_ff;
            endcase
            mstep_in = mstep_ff + 2'd1;
            state_in = (mstep_ff == 2'd2) ? S_ADD : S_MUL;
         end
         S_ADD: begin
            case (act_ff)
               ACT_ADD: sum_in = x0_ff + x1_ff;
               ACT_SUB: sum_in = x0_ff - x1_ff;
               default: sum_in = x0_ff;
            endcase
            state_in = S_ABS;
         end
         S_ABS: begin
            nmag_in = sum_ff[DW] ? sum_negv[DW-1:0] : sum_ff[DW-1:0];
            nneg_in = sum_ff[DW];
            if (act_ff inside {ACT_MUL, ACT_DIV}) begin
               dmag_in = x1_ff[DW] ? x1_negv[DW-1:0] : x1_ff[DW-1:0];
               dneg_in = x1_ff[DW];
            end else begin
               dmag_in = x2_ff;
               dneg_in = 1'b0;
            end
            ph_in    = PH_R;
            state_in = S_NORM;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {den_ext[RES_DEN_W-1:0], num_val[RES_NUM_W-1:0]};
               rsp_user_in  = (dmag_ff == '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= PH_A;
         mstep_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         mstep_ff     <= mstep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      bn_raw_ff   <= bn_raw_in;
      bd_raw_ff   <= bd_raw_in;
      nmag_ff     <= nmag_in;
      dmag_ff     <= dmag_in;
      nneg_ff     <= nneg_in;
      dneg_ff     <= dneg_in;
      m_ff        <= m_in;
      g_ff        <= g_in;
      an_ff       <= an_in;
      ad_ff       <= ad_in;
      bn_ff       <= bn_in;
      bd_ff       <= bd_in;
      an_neg_ff   <= an_neg_in;
      ad_neg_ff   <= ad_neg_in;
      bn_neg_ff   <= bn_neg_in;
      bd_neg_ff   <= bd_neg_in;
      prod_ff     <= prod_in;
      prod_neg_ff <= prod_neg_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/rau_checker.sv =====
module rau_checker #(
   parameter int OPERAND_WIDTH = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rau_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser
);
   import rau_pkg::*;

   logic [RES_NUM_W-1:0] res_num;
   logic [RES_DEN_W-1:0] res_den;

   assign res_num = rsp_tdata[RES_NUM_W-1:0];
   assign res_den = rsp_tdata[RSP_TDATA_W-1:RES_NUM_W];

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // one item at a time: no request taken right after one was accepted
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   a_den_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> res_den == '0)
      else $error("den_zero flagged with nonzero denominator");

   // a zero result over a nonzero denominator is 0/1 (checked for operands up to 16 bits)
   a_zero_num: assert property (@(posedge clock) disable iff (reset)
      (OPERAND_WIDTH <= 16) && rsp_tvalid && !rsp_tuser && (res_num == '0)
      |-> res_den == RES_DEN_W'(1))
      else $error("zero result not reduced to 0/1");

endmodule

bind rational_arith_unit rau_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_rau_checker (.*);
